// ----- hw/rtl/fvj_pkg.sv -----
// ----------------------------------------------------------------------------
// fvj_pkg
// Shared types and constants for the flash value journal.
// ----------------------------------------------------------------------------
package fvj_pkg;

  // width of one journal word
  localparam int unsigned DATA_W = 16;

  // erased slot marker
  localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fvj_state_t;

endpackage

// ----- hw/rtl/flash_value_journal.sv -----
// ----------------------------------------------------------------------------
// flash_value_journal
// Append-only journal of 16-bit words with load and store requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (in_req_type, in_new_value) is taken at a clock edge with
//   start high and busy low. Load returns the last journal word (0 if empty);
//   store appends the word unless it equals the current word or is 0xFFFF,
//   and erases the whole journal first when the last slot is in use.
//   Each request gives one result word on out_last_value, out_accepted and
//   out_erased, marked by out_valid for exactly one cycle.
//   out_valid and the result word are registered from ST_EXEC, the state
//   entered at the accepting edge, at which the journal RAM read is also
//   registered. Busy then holds off the next request word while the read
//   data is compared and written back, so no new word is taken while one
//   is in ST_EXEC.
//   A fill count marks which slots hold words, so reset and a full erase
//   take effect at once with no sweep of the RAM.
//   Reset (rst_n low, synchronous) empties the journal and clears the pointer.
//   The receiver cannot stall: each result word must be taken when shown.
// ----------------------------------------------------------------------------
module flash_value_journal #(
  parameter int unsigned JOURNAL_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [fvj_pkg::DATA_W-1:0] in_new_value,
  output logic                       out_valid,
  output logic [fvj_pkg::DATA_W-1:0] out_last_value,
  output logic                       out_accepted,
  output logic                       out_erased
);

  localparam int unsigned AW = $clog2(JOURNAL_ENTRIES);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [fvj_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [fvj_pkg::DATA_W-1:0] mem_rdata;

  // journal storage
  fvj_ram #(
    .WIDTH (fvj_pkg::DATA_W),
    .DEPTH (JOURNAL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request sequencer
  fvj_core #(
    .JOURNAL_ENTRIES (JOURNAL_ENTRIES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_last_value (out_last_value),
    .out_accepted   (out_accepted),
    .out_erased     (out_erased),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

endmodule

// ----- hw/rtl/fvj_ram.sv -----
// ----------------------------------------------------------------------------
// fvj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fvj_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fvj_core.sv -----
// ----------------------------------------------------------------------------
// fvj_core
// Request sequencer and datapath: reads the word at the pointer, compares,
// appends or rolls over, and registers the result word.
// ----------------------------------------------------------------------------
module fvj_core #(
  parameter int unsigned JOURNAL_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [fvj_pkg::DATA_W-1:0]         in_new_value,
  output logic                               out_valid,
  output logic [fvj_pkg::DATA_W-1:0]         out_last_value,
  output logic                               out_accepted,
  output logic                               out_erased,
  output logic                               mem_we,
  output logic [$clog2(JOURNAL_ENTRIES)-1:0] mem_waddr,
  output logic [fvj_pkg::DATA_W-1:0]         mem_wdata,
  output logic [$clog2(JOURNAL_ENTRIES)-1:0] mem_raddr,
  input  logic [fvj_pkg::DATA_W-1:0]         mem_rdata
);

  localparam int unsigned AW = $clog2(JOURNAL_ENTRIES);
  localparam int unsigned CW = $clog2(JOURNAL_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(JOURNAL_ENTRIES - 1);

  fvj_pkg::fvj_state_t state_r, state_nxt;

  logic                       req_r;
  logic [fvj_pkg::DATA_W-1:0] val_r;
  // slots 0 .. fill-1 hold words, the rest read as erased
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [fvj_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic                       out_acc_r, out_acc_nxt;
  logic                       out_ers_r, out_ers_nxt;

  logic                       empty;
  logic                       reject;
  logic                       full;
  logic [fvj_pkg::DATA_W-1:0] cur_value;

  // current word, masked to zero on an empty journal
  assign empty     = (fill_r == '0);
  assign cur_value = empty ? '0 : mem_rdata;
  assign full      = !empty && (ptr_r == LAST_SLOT);
  assign reject    = (val_r == fvj_pkg::ERASED_WORD) || (!empty && (val_r == mem_rdata));

  assign mem_raddr = ptr_r;
  assign busy      = (state_r != fvj_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fvj_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fvj_pkg::ST_EXEC;
        end
      end
      fvj_pkg::ST_EXEC: begin
        state_nxt = fvj_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fvj_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = val_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_acc_nxt   = out_acc_r;
    out_ers_nxt   = out_ers_r;
    unique case (state_r)
      fvj_pkg::ST_IDLE: begin
      end
      fvj_pkg::ST_EXEC: begin
        out_valid_nxt = 1'b1;
        out_ers_nxt   = 1'b0;
        if (req_r == fvj_pkg::REQ_LOAD) begin
          // last word of the journal sits at the pointer
          out_value_nxt = cur_value;
          out_acc_nxt   = 1'b1;
        end else if (reject) begin
          out_value_nxt = cur_value;
          out_acc_nxt   = 1'b0;
        end else begin
          out_value_nxt = val_r;
          out_acc_nxt   = 1'b1;
          mem_we        = 1'b1;
          if (empty || full) begin
            // first word, or roll over after a full erase
            mem_waddr   = '0;
            ptr_nxt     = '0;
            fill_nxt    = CW'(1);
            out_ers_nxt = full;
          end else begin
            mem_waddr = ptr_r + AW'(1);
            ptr_nxt   = ptr_r + AW'(1);
            fill_nxt  = fill_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fvj_pkg::ST_IDLE;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result word registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req_type;
      val_r <= in_new_value;
    end
    out_value_r <= out_value_nxt;
    out_acc_r   <= out_acc_nxt;
    out_ers_r   <= out_ers_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_last_value = out_value_r;
  assign out_accepted   = out_acc_r;
  assign out_erased     = out_ers_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flash_value_journal. A local mirror of the journal
// predicts every result word: load scans, appends, rejected stores and the
// full erase on wrap. Each result is compared field by field with the oldest
// prediction as it shows up on the result strobe.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DATA_W       = fvj_pkg::DATA_W;
  localparam int unsigned SLOTS        = 256;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_GAP      = 17;

  typedef struct packed {
    logic [DATA_W-1:0] last_value;
    logic              accepted;
    logic              erased;
  } result_word_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic              in_req_type  = fvj_pkg::REQ_LOAD;
  logic [DATA_W-1:0] in_new_value = '0;
  logic              busy;
  logic              out_valid;
  logic [DATA_W-1:0] out_last_value;
  logic              out_accepted;
  logic              out_erased;

  // journal mirror and the queue of predicted result words
  logic [DATA_W-1:0] journal_mirror [SLOTS];
  int unsigned       mirror_ptr;
  result_word_t      pending_results [$];
  int unsigned       error_count = 0;
  int unsigned       idle_cycles = 0;
  bit                no_gaps     = 1'b0;

  always #4 clk = ~clk;

  flash_value_journal #(
    .JOURNAL_ENTRIES(SLOTS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_last_value(out_last_value),
    .out_accepted  (out_accepted),
    .out_erased    (out_erased)
  );

  // empty the mirror, as reset and a full erase do
  function automatic void wipe_mirror();
    for (int unsigned i = 0; i < SLOTS; i++) journal_mirror[i] = fvj_pkg::ERASED_WORD;
  endfunction

  // expected result word for one request, updating the mirror
  function automatic result_word_t predict_journal(logic rt,
                                                   logic [DATA_W-1:0] v);
    result_word_t      r;
    int unsigned       i;
    int unsigned       slot;
    int unsigned       dst;
    logic [DATA_W-1:0] cur;
    r.last_value = '0;
    r.accepted   = 1'b1;
    r.erased     = 1'b0;
    if (rt == fvj_pkg::REQ_LOAD) begin
      // scan up to the first erased slot
      mirror_ptr = 0;
      i = 0;
      while (i < SLOTS && journal_mirror[i] != fvj_pkg::ERASED_WORD) begin
        r.last_value = journal_mirror[i];
        mirror_ptr   = i;
        i++;
      end
    end else begin
      slot = (mirror_ptr < SLOTS) ? mirror_ptr : 0;
      cur  = journal_mirror[slot];
      if (v == fvj_pkg::ERASED_WORD || v == cur) begin
        // rejected: report current word, or 0 on an empty journal
        r.accepted   = 1'b0;
        r.last_value = (cur == fvj_pkg::ERASED_WORD) ? '0 : cur;
      end else begin
        if (cur == fvj_pkg::ERASED_WORD) begin
          dst = 0;
        end else begin
          dst = slot + 1;
          if (dst >= SLOTS) begin
            wipe_mirror();
            r.erased = 1'b1;
            dst      = 0;
          end
        end
        journal_mirror[dst] = v;
        mirror_ptr          = dst;
        r.last_value        = v;
      end
    end
    return r;
  endfunction

  // value mix that hits repeats, the erased marker and the full range
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return DATA_W'($urandom_range(0, 3));
      2:       return fvj_pkg::ERASED_WORD;
      3:       return journal_mirror[mirror_ptr];
      4:       return DATA_W'($urandom_range(16'hFFF0, 16'hFFFE));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // send one request word and queue its prediction once accepted
  task automatic send_word(input logic rt, input logic [DATA_W-1:0] v);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start        <= 1'b0;
      in_req_type  <= 1'($urandom_range(0, 1));
      in_new_value <= DATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= rt;
    in_new_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_journal(rt, v));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // empty journal, erased marker, zero and the field extremes
  task automatic test_empty_journal();
    send_word(fvj_pkg::REQ_LOAD,  16'h1234);
    send_word(fvj_pkg::REQ_STORE, fvj_pkg::ERASED_WORD);
    send_word(fvj_pkg::REQ_STORE, 16'h0000);
    send_word(fvj_pkg::REQ_STORE, 16'h0000);
    send_word(fvj_pkg::REQ_STORE, fvj_pkg::ERASED_WORD);
    send_word(fvj_pkg::REQ_LOAD,  fvj_pkg::ERASED_WORD);
    send_word(fvj_pkg::REQ_STORE, 16'hFFFE);
    send_word(fvj_pkg::REQ_STORE, 16'h8000);
    send_word(fvj_pkg::REQ_STORE, 16'h0001);
    send_word(fvj_pkg::REQ_STORE, 16'h0001);
    send_word(fvj_pkg::REQ_STORE, 16'h7FFF);
    send_word(fvj_pkg::REQ_LOAD,  16'h0000);
    send_word(fvj_pkg::REQ_STORE, 16'h7FFF);
    send_word(fvj_pkg::REQ_STORE, 16'hAAAA);
    send_word(fvj_pkg::REQ_STORE, 16'h5555);
    send_word(fvj_pkg::REQ_LOAD,  16'hFFFF);
  endtask

  // fill every slot, load on a full journal, then wrap with an erase
  task automatic test_full_journal();
    while (!(mirror_ptr == SLOTS - 1 && journal_mirror[SLOTS-1] != fvj_pkg::ERASED_WORD))
      send_word(fvj_pkg::REQ_STORE, DATA_W'($urandom));
    send_word(fvj_pkg::REQ_LOAD,  DATA_W'($urandom));
    send_word(fvj_pkg::REQ_STORE, journal_mirror[SLOTS-1]);
    send_word(fvj_pkg::REQ_STORE, ~journal_mirror[SLOTS-1] & 16'h7FFF);
    send_word(fvj_pkg::REQ_LOAD,  DATA_W'($urandom));
  endtask

  // sender holds off until every result is in, then resumes back to back
  task automatic test_drained_restart();
    for (int unsigned n = 0; n < 10; n++) send_word(fvj_pkg::REQ_STORE, pick_value());
    start <= 1'b0;
    wait_drained();
    no_gaps = 1'b1;
    for (int unsigned n = 0; n < 10; n++) send_word(fvj_pkg::REQ_STORE, pick_value());
    no_gaps = 1'b0;
  endtask

  // mostly stores with random content, loads now and then
  task automatic test_random_mix(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) send_word(fvj_pkg::REQ_LOAD, DATA_W'($urandom));
      else send_word(fvj_pkg::REQ_STORE, pick_value());
    end
    no_gaps = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual last_value %h accepted %b erased %b",
                 $time, out_last_value, out_accepted, out_erased);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_last_value !== want.last_value) begin
          $display("%0t: last_value mismatch: expected %h, actual %h",
                   $time, want.last_value, out_last_value);
          error_count++;
        end
        if (out_accepted !== want.accepted) begin
          $display("%0t: accepted mismatch: expected %b, actual %b",
                   $time, want.accepted, out_accepted);
          error_count++;
        end
        if (out_erased !== want.erased) begin
          $display("%0t: erased mismatch: expected %b, actual %b",
                   $time, want.erased, out_erased);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of either kind
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    wipe_mirror();
    mirror_ptr = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_journal();
    test_full_journal();
    test_drained_restart();
    test_random_mix(600);
    no_gaps = 1'b1;
    test_full_journal();
    no_gaps = 1'b0;
    test_random_mix(500);
    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- flash_value_journal.f -----
hw/rtl/fvj_pkg.sv
hw/rtl/fvj_ram.sv
hw/rtl/fvj_core.sv
hw/rtl/flash_value_journal.sv
dv/tb.sv
